FILE: rtl/water_grid_path_search_macros.svh
// Assertion shorthands for the path search checker.
`ifndef WATER_GRID_PATH_SEARCH_MACROS_SVH
`define WATER_GRID_PATH_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define WGPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define WGPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/wgps_pkg.sv
`default_nettype none
package wgps_pkg;

  localparam int GRID_W         = 64;
  localparam int GRID_H         = 64;
  localparam int XW             = $clog2(GRID_W);
  localparam int YW             = $clog2(GRID_H);
  localparam int CELLS          = GRID_W * GRID_H;
  localparam int CELL_W         = XW + YW;
  localparam int PLEN_W         = CELL_W + 1;
  localparam int NB_W           = ((XW > YW) ? XW : YW) + 2;
  localparam int QUEUE_DEPTH    = 8192;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = QPTR_W + 1;
  localparam int COST_FRAC_BITS = 16;
  localparam int COST_W         = 32;

  localparam logic [63:0] SQRT2_Q32 = 64'd6074001000;
  localparam logic [COST_W-1:0] STRAIGHT = COST_W'(64'd1 << COST_FRAC_BITS);
  localparam logic [COST_W-1:0] DIAG =
    COST_W'((SQRT2_Q32 + (64'd1 << (31 - COST_FRAC_BITS))) >> (32 - COST_FRAC_BITS));

  typedef enum logic [1:0] {
    FN_LOAD   = 2'd0,
    FN_SEARCH = 2'd1,
    FN_READ   = 2'd2,
    FN_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    SS_OK       = 2'd0,
    SS_NO_PATH  = 2'd1,
    SS_OVERFLOW = 2'd2,
    SS_BEYOND   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    REG_START_X  = 3'd0,
    REG_START_Y  = 3'd1,
    REG_FINISH_X = 3'd2,
    REG_FINISH_Y = 3'd3,
    REG_MAP_W    = 3'd4,
    REG_MAP_H    = 3'd5
  } reg_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_START,
    S_POP,
    S_POP_W,
    S_CUR_W,
    S_NB,
    S_NB_W,
    S_TRACE,
    S_TR_W,
    S_READ_W,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [5:0] start_x;
    logic [5:0] start_y;
    logic [5:0] finish_x;
    logic [5:0] finish_y;
    logic [6:0] map_w;
    logic [6:0] map_h;
  } cfg_t;

  typedef struct packed {
    logic              visited;
    logic [COST_W-1:0] cost;
    logic [2:0]        dir;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef struct packed {
    logic              node_we;
    logic [CELL_W-1:0] node_addr;
    node_t             node_wdata;
    logic              water_we;
    logic [CELL_W-1:0] water_addr;
    logic              water_wdata;
    logic              queue_we;
    logic [QPTR_W-1:0] queue_addr;
    logic [CELL_W-1:0] queue_wdata;
    logic              path_we;
    logic [CELL_W-1:0] path_addr;
    logic [CELL_W-1:0] path_wdata;
  } mem_req_t;

  typedef struct packed {
    node_t             node;
    logic              water;
    logic [CELL_W-1:0] queue;
    logic [CELL_W-1:0] path;
  } mem_rsp_t;

  // Step codes run in row order: dy then dx, each from -1 to 1.
  function automatic logic [NB_W-1:0] step_dx(input logic [2:0] d);
    logic [NB_W-1:0] r;
    case (d)
      3'd0, 3'd3, 3'd5: r = '1;
      3'd1, 3'd6:       r = '0;
      default:          r = NB_W'(1);
    endcase
    return r;
  endfunction

  function automatic logic [NB_W-1:0] step_dy(input logic [2:0] d);
    logic [NB_W-1:0] r;
    case (d)
      3'd0, 3'd1, 3'd2: r = '1;
      3'd3, 3'd4:       r = '0;
      default:          r = NB_W'(1);
    endcase
    return r;
  endfunction

  function automatic logic step_diag(input logic [2:0] d);
    logic r;
    case (d)
      3'd0, 3'd2, 3'd5, 3'd7: r = 1'b1;
      default:                r = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/water_grid_path_search.sv
`default_nettype none
// Channel   Handshake                         Word
// input     in_valid_i / in_ready_o           func, cell_x, cell_y, water, path_index
// output    out_valid_o / out_ready_i         status, path_length, point_x, point_y
// config    cfg_we_i (no wait)                cfg_idx_i, cfg_wdata_i
//
// Load, unused codes and reads past the path go straight to the result; a read on the
// path first waits on the path store. A search first clears the node memory, then pops
// cells and checks each one's in-bounds neighbours in turn, then traces the path back
// point by point; the single-port node memory paces each of these steps.
// Reset: a sweep makes every cell land with input held off; no path.
// A new word is taken while a result waits; its own result then waits too.
module water_grid_path_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [5:0]  cell_x_i,
  input  logic [5:0]  cell_y_i,
  input  logic        water_i,
  input  logic [11:0] path_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [12:0] path_length_o,
  output logic [5:0]  point_x_o,
  output logic [5:0]  point_y_o
);
  import wgps_pkg::*;

  cfg_t     cfg_q, cfg_d;
  mem_req_t req;
  mem_rsp_t rsp;
  logic [NODE_W-1:0] node_rdata;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_START_X:  cfg_d.start_x  = cfg_wdata_i[5:0];
        REG_START_Y:  cfg_d.start_y  = cfg_wdata_i[5:0];
        REG_FINISH_X: cfg_d.finish_x = cfg_wdata_i[5:0];
        REG_FINISH_Y: cfg_d.finish_y = cfg_wdata_i[5:0];
        REG_MAP_W:    cfg_d.map_w    = cfg_wdata_i;
        REG_MAP_H:    cfg_d.map_h    = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{start_x: '0, start_y: '0, finish_x: '0, finish_y: '0,
                 map_w: 7'd64, map_h: 7'd64};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Water bit per cell; the controller sweeps it to all land after reset.
  // Visited marks are cleared by a sweep of the node memory per search.
  wgps_ram #(.WIDTH(1), .DEPTH(CELLS)) u_water (
    .clk_i   (clk_i),
    .we_i    (req.water_we),
    .addr_i  (req.water_addr),
    .wdata_i (req.water_wdata),
    .rdata_o (rsp.water)
  );

  wgps_ram #(.WIDTH(NODE_W), .DEPTH(CELLS)) u_node (
    .clk_i   (clk_i),
    .we_i    (req.node_we),
    .addr_i  (req.node_addr),
    .wdata_i (req.node_wdata),
    .rdata_o (node_rdata)
  );
  assign rsp.node = node_t'(node_rdata);

  wgps_ram #(.WIDTH(CELL_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .we_i    (req.queue_we),
    .addr_i  (req.queue_addr),
    .wdata_i (req.queue_wdata),
    .rdata_o (rsp.queue)
  );

  wgps_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_path (
    .clk_i   (clk_i),
    .we_i    (req.path_we),
    .addr_i  (req.path_addr),
    .wdata_i (req.path_wdata),
    .rdata_o (rsp.path)
  );

  wgps_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .cell_x_i      (cell_x_i),
    .cell_y_i      (cell_y_i),
    .water_i       (water_i),
    .path_index_i  (path_index_i),
    .cfg_i         (cfg_q),
    .mem_req_o     (req),
    .mem_rsp_i     (rsp),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .path_length_o (path_length_o),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o)
  );

endmodule
`default_nettype wire

FILE: rtl/wgps_ram.sv
`default_nettype none
module wgps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/wgps_ctrl.sv
`default_nettype none
module wgps_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         func_i,
  input  logic [5:0]                         cell_x_i,
  input  logic [5:0]                         cell_y_i,
  input  logic                               water_i,
  input  logic [11:0]                        path_index_i,
  input  wgps_pkg::cfg_t                     cfg_i,
  output wgps_pkg::mem_req_t                 mem_req_o,
  input  wgps_pkg::mem_rsp_t                 mem_rsp_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         status_o,
  output logic [12:0]                        path_length_o,
  output logic [5:0]                         point_x_o,
  output logic [5:0]                         point_y_o
);
  import wgps_pkg::*;

  state_e              state_q, state_d;
  logic [CELL_W-1:0]   clr_q, clr_d;
  logic [QPTR_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic [CELL_W-1:0]   cur_q, cur_d;
  logic [COST_W-1:0]   cost_q, cost_d;
  logic [2:0]          dir_q, dir_d;
  logic [PLEN_W-1:0]   len_q, len_d;
  logic [PLEN_W-1:0]   pcnt_q, pcnt_d;
  status_e             status_q, status_d;
  logic                is_rd_q, is_rd_d;
  status_e             rd_status_q, rd_status_d;
  logic [CELL_W-1:0]   point_q, point_d;
  logic                out_valid_q, out_valid_d;
  logic [1:0]          out_status_q, out_status_d;
  logic [PLEN_W-1:0]   out_len_q, out_len_d;
  logic [CELL_W-1:0]   out_point_q, out_point_d;

  logic [CELL_W-1:0]   start_cell, finish_cell, nb_cell, back_cell;
  logic [NB_W-1:0]     nx, ny, px, py, mw, mh;
  logic                nb_in, nb_fin, take, full, rd_hit;
  logic [COST_W:0]     sum;
  logic [COST_W-1:0]   nc;
  logic [PLEN_W-1:0]   rd_off;
  func_e               func;

  assign func        = func_e'(func_i);
  assign start_cell  = {cfg_i.start_y, cfg_i.start_x};
  assign finish_cell = {cfg_i.finish_y, cfg_i.finish_x};

  // Clamp map size to the grid.
  assign mw = (NB_W'(cfg_i.map_w) > NB_W'(GRID_W)) ? NB_W'(GRID_W) : NB_W'(cfg_i.map_w);
  assign mh = (NB_W'(cfg_i.map_h) > NB_W'(GRID_H)) ? NB_W'(GRID_H) : NB_W'(cfg_i.map_h);

  assign nx      = NB_W'(cur_q[XW-1:0]) + step_dx(dir_q);
  assign ny      = NB_W'(cur_q[CELL_W-1:XW]) + step_dy(dir_q);
  assign nb_in   = !nx[NB_W-1] && !ny[NB_W-1] && (nx < mw) && (ny < mh);
  assign nb_cell = {ny[YW-1:0], nx[XW-1:0]};
  assign nb_fin  = (nb_cell == finish_cell);

  assign sum  = {1'b0, cost_q} + {1'b0, (step_diag(dir_q) ? DIAG : STRAIGHT)};
  assign nc   = sum[COST_W] ? '1 : sum[COST_W-1:0];
  assign take = (mem_rsp_i.water || nb_fin) &&
                (!mem_rsp_i.node.visited || (nc < mem_rsp_i.node.cost));
  assign full = (cnt_q == QCNT_W'(QUEUE_DEPTH));

  // Step back along the stored parent direction.
  assign px        = NB_W'(cur_q[XW-1:0]) - step_dx(mem_rsp_i.node.dir);
  assign py        = NB_W'(cur_q[CELL_W-1:XW]) - step_dy(mem_rsp_i.node.dir);
  assign back_cell = {py[YW-1:0], px[XW-1:0]};

  // Path store holds finish first; index from the start end.
  assign rd_hit = (status_q == SS_OK) && (PLEN_W'(path_index_i) < pcnt_q);
  assign rd_off = pcnt_q - PLEN_W'(1) - PLEN_W'(path_index_i);

  always_comb begin : next_state
    state_d = state_q;
    case (state_q)
      S_INIT:   if (clr_q == CELL_W'(CELLS - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          case (func)
            FN_SEARCH: state_d = S_CLEAR;
            FN_READ:   state_d = rd_hit ? S_READ_W : S_RESP;
            default:   state_d = S_RESP;
          endcase
        end
      end
      S_CLEAR:  if (clr_q == CELL_W'(CELLS - 1)) state_d = S_START;
      S_START:  state_d = S_POP;
      S_POP:    state_d = (cnt_q == '0) ? S_RESP : S_POP_W;
      S_POP_W:  state_d = (mem_rsp_i.queue == finish_cell) ? S_TRACE : S_CUR_W;
      S_CUR_W:  state_d = S_NB;
      S_NB: begin
        if (nb_in) begin
          state_d = S_NB_W;
        end else if (dir_q == 3'd7) begin
          state_d = S_POP;
        end
      end
      S_NB_W: begin
        if (take && full) begin
          state_d = S_RESP;
        end else begin
          state_d = (dir_q == 3'd7) ? S_POP : S_NB;
        end
      end
      S_TRACE:  state_d = (cur_q == start_cell) ? S_RESP : S_TR_W;
      S_TR_W:   state_d = S_TRACE;
      S_READ_W: state_d = S_RESP;
      S_RESP:   if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin : outputs
    mem_req_o    = '0;
    clr_d        = clr_q;
    head_d       = head_q;
    tail_d       = tail_q;
    cnt_d        = cnt_q;
    cur_d        = cur_q;
    cost_d       = cost_q;
    dir_d        = dir_q;
    len_d        = len_q;
    pcnt_d       = pcnt_q;
    status_d     = status_q;
    is_rd_d      = is_rd_q;
    rd_status_d  = rd_status_q;
    point_d      = point_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_len_d    = out_len_q;
    out_point_d  = out_point_q;

    case (state_q)
      S_INIT: begin
        // Sweep every cell to land after reset.
        mem_req_o.water_we   = 1'b1;
        mem_req_o.water_addr = clr_q;
        clr_d                = clr_q + CELL_W'(1);
      end
      S_IDLE: begin
        if (in_valid_i) begin
          is_rd_d     = (func == FN_READ);
          rd_status_d = (status_q == SS_OK) ? SS_BEYOND : status_q;
          point_d     = '0;
          case (func)
            FN_LOAD: begin
              mem_req_o.water_we    = 1'b1;
              mem_req_o.water_addr  = {cell_y_i, cell_x_i};
              mem_req_o.water_wdata = water_i;
            end
            FN_SEARCH: begin
              clr_d    = '0;
              head_d   = '0;
              tail_d   = '0;
              cnt_d    = '0;
              pcnt_d   = '0;
              status_d = SS_NO_PATH;
            end
            FN_READ: begin
              rd_status_d         = rd_hit ? SS_OK : rd_status_d;
              mem_req_o.path_addr = rd_off[CELL_W-1:0];
            end
            default: ;
          endcase
        end
      end
      S_CLEAR: begin
        mem_req_o.node_we   = 1'b1;
        mem_req_o.node_addr = clr_q;
        clr_d               = clr_q + CELL_W'(1);
      end
      S_START: begin
        mem_req_o.node_we            = 1'b1;
        mem_req_o.node_addr          = start_cell;
        mem_req_o.node_wdata.visited = 1'b1;
        mem_req_o.queue_we           = 1'b1;
        mem_req_o.queue_addr         = tail_q;
        mem_req_o.queue_wdata        = start_cell;
        tail_d                       = tail_q + QPTR_W'(1);
        cnt_d                        = cnt_q + QCNT_W'(1);
      end
      S_POP: begin
        mem_req_o.queue_addr = head_q;
        if (cnt_q != '0) begin
          head_d = head_q + QPTR_W'(1);
          cnt_d  = cnt_q - QCNT_W'(1);
        end
      end
      S_POP_W: begin
        cur_d               = mem_rsp_i.queue;
        mem_req_o.node_addr = mem_rsp_i.queue;
        if (mem_rsp_i.queue == finish_cell) begin
          // Finish leaves the queue: record it as point zero of the trace.
          mem_req_o.path_we    = 1'b1;
          mem_req_o.path_addr  = '0;
          mem_req_o.path_wdata = mem_rsp_i.queue;
          len_d                = PLEN_W'(1);
        end
      end
      S_CUR_W: begin
        cost_d = mem_rsp_i.node.cost;
        dir_d  = '0;
      end
      S_NB: begin
        mem_req_o.node_addr  = nb_cell;
        mem_req_o.water_addr = nb_cell;
        if (!nb_in) begin
          dir_d = dir_q + 3'd1;
        end
      end
      S_NB_W: begin
        dir_d = dir_q + 3'd1;
        if (take) begin
          if (full) begin
            status_d = SS_OVERFLOW;
            pcnt_d   = '0;
          end else begin
            mem_req_o.queue_we           = 1'b1;
            mem_req_o.queue_addr         = tail_q;
            mem_req_o.queue_wdata        = nb_cell;
            mem_req_o.node_we            = 1'b1;
            mem_req_o.node_addr          = nb_cell;
            mem_req_o.node_wdata.visited = 1'b1;
            mem_req_o.node_wdata.cost    = nc;
            mem_req_o.node_wdata.dir     = dir_q;
            tail_d                       = tail_q + QPTR_W'(1);
            cnt_d                        = cnt_q + QCNT_W'(1);
          end
        end
      end
      S_TRACE: begin
        mem_req_o.node_addr = cur_q;
        if (cur_q == start_cell) begin
          status_d = SS_OK;
          pcnt_d   = len_q;
        end
      end
      S_TR_W: begin
        mem_req_o.path_we    = 1'b1;
        mem_req_o.path_addr  = len_q[CELL_W-1:0];
        mem_req_o.path_wdata = back_cell;
        len_d                = len_q + PLEN_W'(1);
        cur_d                = back_cell;
      end
      S_READ_W: begin
        point_d = mem_rsp_i.path;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = is_rd_q ? rd_status_q : status_q;
          out_len_d    = pcnt_q;
          out_point_d  = point_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      clr_q        <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      cnt_q        <= '0;
      cur_q        <= '0;
      cost_q       <= '0;
      dir_q        <= '0;
      len_q        <= '0;
      pcnt_q       <= '0;
      status_q     <= SS_NO_PATH;
      is_rd_q      <= 1'b0;
      rd_status_q  <= SS_NO_PATH;
      point_q      <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_len_q    <= '0;
      out_point_q  <= '0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      cnt_q        <= cnt_d;
      cur_q        <= cur_d;
      cost_q       <= cost_d;
      dir_q        <= dir_d;
      len_q        <= len_d;
      pcnt_q       <= pcnt_d;
      status_q     <= status_d;
      is_rd_q      <= is_rd_d;
      rd_status_q  <= rd_status_d;
      point_q      <= point_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_len_q    <= out_len_d;
      out_point_q  <= out_point_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign path_length_o = out_len_q;
  assign point_x_o     = out_point_q[XW-1:0];
  assign point_y_o     = out_point_q[CELL_W-1:XW];

endmodule
`default_nettype wire

FILE: rtl/wgps_checker.sv
`default_nettype none
`include "water_grid_path_search_macros.svh"
module wgps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [12:0] path_length_o,
  input logic [5:0]  point_x_o,
  input logic [5:0]  point_y_o
);
  import wgps_pkg::*;

  `WGPS_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(path_length_o), "result word dropped or changed while stalled")
  `WGPS_ASSERT_IMP(a_ok_len, out_valid_o && (status_o == SS_OK || status_o == SS_BEYOND), path_length_o != '0, "found path with zero length")
  `WGPS_ASSERT_IMP(a_fail_len, out_valid_o && (status_o == SS_NO_PATH || status_o == SS_OVERFLOW), path_length_o == '0, "failed search with nonzero length")
  `WGPS_ASSERT_IMP(a_point_zero, out_valid_o && status_o != SS_OK, point_x_o == '0 && point_y_o == '0, "point given without a valid read")

endmodule

bind water_grid_path_search wgps_checker u_checker (.*);
`default_nettype wire

FILE: test/tb_water_grid_path_search.sv
`timescale 1ns / 100ps
module tb_water_grid_path_search;
  import wgps_pkg::*;

  typedef struct {
    status_e    st;
    bit [12:0]  len;
    bit [5:0]   px;
    bit [5:0]   py;
  } path_reply_t;

  class path_board;
    bit          water[CELLS];
    bit          seen[CELLS];
    bit [31:0]   cost[CELLS];
    bit [2:0]    dir[CELLS];
    bit [11:0]   fifo[QUEUE_DEPTH];
    int          head, tail, count;
    bit [11:0]   route[CELLS];
    int          route_len;
    status_e     st;
    bit [5:0]    sx, sy, fx, fy;
    bit [6:0]    mw, mh;
    path_reply_t replies[$];
    int          errors;
    int          step_x[8] = '{-1, 0, 1, -1, 1, -1, 0, 1};
    int          step_y[8] = '{-1, -1, -1, 0, 0, 1, 1, 1};

    function new();
      st = SS_NO_PATH;
      mw = 7'd64;
      mh = 7'd64;
    endfunction

    function void set_reg(reg_e r, bit [6:0] v);
      case (r)
        REG_START_X:  sx = v[5:0];
        REG_START_Y:  sy = v[5:0];
        REG_FINISH_X: fx = v[5:0];
        REG_FINISH_Y: fy = v[5:0];
        REG_MAP_W:    mw = v;
        REG_MAP_H:    mh = v;
        default: ;
      endcase
    endfunction

    // Follow parent steps back to start, then fill the route from the finish end.
    function void trace(int s, int f);
      int c, len, d, x, y, k;
      c = f;
      len = 1;
      while (c != s && len <= CELLS) begin
        d = dir[c];
        x = c % GRID_W - step_x[d];
        y = c / GRID_W - step_y[d];
        if (x < 0 || y < 0 || x >= GRID_W || y >= GRID_H) return;
        c = y * GRID_W + x;
        len++;
      end
      if (c != s || len > CELLS) return;
      c = f;
      for (k = len; k > 0; k--) begin
        route[k-1] = 12'(c);
        if (k > 1) begin
          d = dir[c];
          c = (c / GRID_W - step_y[d]) * GRID_W + (c % GRID_W - step_x[d]);
        end
      end
      route_len = len;
      st = SS_OK;
    endfunction

    function void search();
      int s, cur, cx, cy, nx, ny, n, d, w, h;
      bit [32:0] nc;
      st = SS_NO_PATH;
      route_len = 0;
      seen = '{default: 0};
      head = 0;
      tail = 0;
      count = 0;
      w = (mw > GRID_W) ? GRID_W : mw;
      h = (mh > GRID_H) ? GRID_H : mh;
      s = sy * GRID_W + sx;
      seen[s] = 1;
      cost[s] = 0;
      fifo[tail] = 12'(s);
      tail = (tail + 1) % QUEUE_DEPTH;
      count++;
      while (count > 0) begin
        cur = fifo[head];
        head = (head + 1) % QUEUE_DEPTH;
        count--;
        cx = cur % GRID_W;
        cy = cur / GRID_W;
        if (cx == fx && cy == fy) begin
          trace(s, cur);
          return;
        end
        for (d = 0; d < 8; d++) begin
          nx = cx + step_x[d];
          ny = cy + step_y[d];
          if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
          n = ny * GRID_W + nx;
          if (!water[n] && !(nx == fx && ny == fy)) continue;
          nc = {1'b0, cost[cur]} + ((step_x[d] != 0 && step_y[d] != 0) ? DIAG : STRAIGHT);
          if (nc[32]) nc = 33'hFFFF_FFFF;
          if (!seen[n] || nc[31:0] < cost[n]) begin
            if (count >= QUEUE_DEPTH) begin
              st = SS_OVERFLOW;
              route_len = 0;
              return;
            end
            fifo[tail] = 12'(n);
            tail = (tail + 1) % QUEUE_DEPTH;
            count++;
            cost[n] = nc[31:0];
            seen[n] = 1;
            dir[n] = 3'(d);
          end
        end
      end
    endfunction

    function void note_word(func_e f, bit [5:0] x, bit [5:0] y, bit wt, bit [11:0] idx);
      path_reply_t r;
      if (f == FN_LOAD) water[y * GRID_W + x] = wt;
      else if (f == FN_SEARCH) search();
      r.st = st;
      r.len = 13'(route_len);
      r.px = 0;
      r.py = 0;
      if (f == FN_READ && st == SS_OK) begin
        if (idx >= route_len) r.st = SS_BEYOND;
        else begin
          r.px = route[idx][5:0];
          r.py = route[idx][11:6];
        end
      end
      replies.insert(replies.size(), r);
    endfunction

    function void check_word(status_e s, bit [12:0] len, bit [5:0] x, bit [5:0] y);
      path_reply_t e;
      if (replies.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
        return;
      end
      e = replies.pop_front();
      if (s != e.st) begin
        $error("status: expected %0d, got %0d", e.st, s);
        errors++;
      end
      if (len != e.len) begin
        $error("path_length: expected %0d, got %0d", e.len, len);
        errors++;
      end
      if (x != e.px) begin
        $error("point_x: expected %0d, got %0d", e.px, x);
        errors++;
      end
      if (y != e.py) begin
        $error("point_y: expected %0d, got %0d", e.py, y);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [6:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  func_i;
  logic [5:0]  cell_x_i;
  logic [5:0]  cell_y_i;
  logic        water_i;
  logic [11:0] path_index_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [12:0] path_length_o;
  logic [5:0]  point_x_o;
  logic [5:0]  point_y_o;

  water_grid_path_search u_top (.*);

  path_board board = new();
  bit        calm;
  bit        long_hold;
  int        stall_left;
  longint    cycles;

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 20_000_000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Note each word taken in; check each word handed out.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      board.note_word(func_e'(func_i), cell_x_i, cell_y_i, water_i, path_index_i);
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_word(status_e'(status_o), path_length_o, point_x_o, point_y_o);
  end

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (long_hold) begin
      long_hold = 0;
      stall_left = 500;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_word(func_e f, bit [5:0] x = 0, bit [5:0] y = 0, bit wt = 0,
                           bit [11:0] idx = 0);
    in_valid_i   <= 1'b1;
    func_i       <= f;
    cell_x_i     <= x;
    cell_y_i     <= y;
    water_i      <= wt;
    path_index_i <= idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every result is back before touching registers.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.replies.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e r, bit [6:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= r;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_reg(r, v);
  endtask

  task automatic set_route(bit [5:0] sx, bit [5:0] sy, bit [5:0] fx, bit [5:0] fy,
                           bit [6:0] w, bit [6:0] h);
    settle();
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_FINISH_X, fx);
    write_reg(REG_FINISH_Y, fy);
    write_reg(REG_MAP_W, w);
    write_reg(REG_MAP_H, h);
  endtask

  task automatic run_round(bit big);
    int w, h, n, i;
    w = big ? 64 : $urandom_range(2, 8);
    h = big ? 64 : $urandom_range(2, 8);
    if ($urandom_range(0, 5) == 0)
      set_route(6'($urandom_range(0, w - 1)), 6'($urandom_range(0, h - 1)),
                6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), 7'(w), 7'(h));
    else
      set_route(6'($urandom_range(0, w - 1)), 6'($urandom_range(0, h - 1)),
                6'($urandom_range(0, w - 1)), 6'($urandom_range(0, h - 1)), 7'(w), 7'(h));
    n = $urandom_range(4, 9);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0)
        send_word(FN_LOAD, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                  1'($urandom_range(0, 1)));
      else if ($urandom_range(0, 15) == 0)
        send_word(FN_NONE, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                  1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)));
      else
        send_word(FN_LOAD, 6'($urandom_range(0, w - 1)), 6'($urandom_range(0, h - 1)),
                  $urandom_range(0, 3) != 0);
    end
    send_word(FN_SEARCH);
    for (i = 0; i < 3; i++)
      send_word(FN_READ, 0, 0, 0,
                12'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                : $urandom_range(0, 12)));
  endtask

  initial begin
    int r;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    func_i       = FN_LOAD;
    cell_x_i     = '0;
    cell_y_i     = '0;
    water_i      = 1'b0;
    path_index_i = '0;
    out_ready_i  = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // No path yet, then an unused code, then extreme cells.
    send_word(FN_READ, 0, 0, 0, 0);
    send_word(FN_NONE, 63, 63, 1, 4095);
    send_word(FN_LOAD, 63, 63, 1);
    send_word(FN_LOAD, 0, 0, 0);
    // Start equals finish on a land cell: one-point path.
    send_word(FN_SEARCH);
    send_word(FN_READ, 0, 0, 0, 0);
    send_word(FN_READ, 0, 0, 0, 1);
    send_word(FN_READ, 0, 0, 0, 4095);
    // Short route with a diagonal last step; oversized width acts as full grid.
    set_route(1, 1, 4, 2, 127, 8);
    send_word(FN_LOAD, 2, 1, 1);
    send_word(FN_LOAD, 3, 1, 1);
    send_word(FN_SEARCH);
    send_word(FN_READ, 0, 0, 0, 0);
    send_word(FN_READ, 0, 0, 0, 3);
    send_word(FN_READ, 0, 0, 0, 4);
    // Zero width: nothing can be entered.
    settle();
    write_reg(REG_MAP_W, 0);
    send_word(FN_SEARCH);
    send_word(FN_READ, 0, 0, 0, 0);
    // Finish beyond the map, then finish equal to a start outside the map.
    set_route(5, 5, 4, 2, 3, 3);
    send_word(FN_SEARCH);
    set_route(5, 5, 5, 5, 3, 3);
    send_word(FN_SEARCH);
    send_word(FN_READ, 0, 0, 0, 0);

    for (r = 0; r < 8; r++) begin
      if (r == 7) calm = 1;
      if (r == 3) begin
        settle();
        long_hold = 1;
      end
      run_round(r == 5);
    end

    settle();
    repeat (50) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
